// ===== sv/corner_preserving_average_5x5_top_macros.svh =====
// Assertion macros shared by the checker of corner_preserving_average_5x5_top.
// Each macro samples on clock; the first two are disabled during reset.
`ifndef CORNER_PRESERVING_AVERAGE_5X5_TOP_MACROS_SVH
`define CORNER_PRESERVING_AVERAGE_5X5_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define CPA_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define CPA_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Check of the cycle that follows a reset cycle.
`define CPA_ASSERT_RST(label, cons, msg) \
   label: assert property (@(posedge clock) reset |=> (cons)) else $error(msg);

`endif

// ===== sv/cpa_pkg.sv =====
// Package for the corner-preserving 5x5 average block.
// Holds widths, constants, register codes and types; no dependencies.
package cpa_pkg;

   localparam int WIN            = 5;
   localparam int TAPS           = WIN * WIN;
   localparam int CENTRE_TAP     = 2 * WIN + 2;
   localparam int PIX_W          = 8;
   localparam int COLS_W         = $clog2(WIN + 1);
   localparam int MASK_COUNT_MAX = 8;
   localparam int MASK_COUNT_DEF = 8;

   // Row sum of up to five pixels, total of five rows, mean after divide by 9
   localparam int ROW_SUM_W   = PIX_W + $clog2(WIN);
   localparam int TOTAL_W     = ROW_SUM_W + $clog2(WIN);
   localparam int MEAN_W      = 10;
   localparam int RECIP_W     = 14;
   localparam int RECIP_SHIFT = 17;
   localparam int PROD_W      = TOTAL_W + RECIP_W;
   localparam int DIFF_W      = 14;

   // floor(x / 9) == (x * 14564) >> 17 for every x below 2^13
   localparam logic [RECIP_W-1:0] RECIP_9    = 14'd14564;
   localparam logic [DIFF_W-1:0]  DIFF_START = 14'd9999;
   localparam logic [PIX_W-1:0]   PIX_MAX    = 8'd255;

   // Configuration port
   localparam int CSR_ADDR_W  = 6;
   localparam int CSR_DATA_W  = 64;
   localparam int PAIR_W      = 2 * TAPS;
   localparam int PAIR_COUNT  = MASK_COUNT_MAX / 2;
   localparam logic [PIX_W-1:0] THRESHOLD_RESET = 8'd128;

   typedef enum logic [2:0] {
      REG_MASK_PAIR_A = 3'd0,
      REG_MASK_PAIR_B = 3'd1,
      REG_MASK_PAIR_C = 3'd2,
      REG_MASK_PAIR_D = 3'd3,
      REG_THRESHOLD   = 3'd4
   } csr_reg_type;

   typedef logic [PIX_W-1:0]          pix_type;
   typedef pix_type [TAPS-1:0]        window_type;
   typedef pix_type [WIN-1:0]         column_type;
   typedef logic [TAPS-1:0]           mask_type;
   typedef mask_type [MASK_COUNT_MAX-1:0] mask_set_type;
   typedef logic [MEAN_W-1:0]         mean_type;

   // Valid flag and centre pixel travelling alongside each pipeline stage
   typedef struct packed {
      logic    valid;
      pix_type centre;
   } stage_tag_type;

endpackage

// ===== sv/cpa_csr.sv =====
// Configuration registers of the corner-preserving average block (APB-style port).
// Depends on cpa_pkg.
module cpa_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [cpa_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [cpa_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [cpa_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready,
   output cpa_pkg::mask_set_type           masks,
   output cpa_pkg::pix_type                threshold
);
   import cpa_pkg::*;

   logic [PAIR_W-1:0] pair_ff [PAIR_COUNT];
   logic [PAIR_W-1:0] pair_in [PAIR_COUNT];
   pix_type           thr_ff;
   pix_type           thr_in;
   csr_reg_type       reg_sel;
   logic              wr_en;

   assign csr_pready = 1'b1;
   assign reg_sel    = csr_reg_type'(csr_paddr[CSR_ADDR_W-1:3]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      pair_in = pair_ff;
      thr_in  = thr_ff;
      if (wr_en) begin
         unique case (reg_sel)
            REG_MASK_PAIR_A: pair_in[0] = csr_pwdata[PAIR_W-1:0];
            REG_MASK_PAIR_B: pair_in[1] = csr_pwdata[PAIR_W-1:0];
            REG_MASK_PAIR_C: pair_in[2] = csr_pwdata[PAIR_W-1:0];
            REG_MASK_PAIR_D: pair_in[3] = csr_pwdata[PAIR_W-1:0];
            REG_THRESHOLD:   thr_in     = csr_pwdata[PIX_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_MASK_PAIR_A: csr_prdata = CSR_DATA_W'(pair_ff[0]);
         REG_MASK_PAIR_B: csr_prdata = CSR_DATA_W'(pair_ff[1]);
         REG_MASK_PAIR_C: csr_prdata = CSR_DATA_W'(pair_ff[2]);
         REG_MASK_PAIR_D: csr_prdata = CSR_DATA_W'(pair_ff[3]);
         REG_THRESHOLD:   csr_prdata = CSR_DATA_W'(thr_ff);
         default:         csr_prdata = '0;
      endcase
   end

   // Mask k sits in the low or high half of pair k/2
   always_comb begin
      for (int k = 0; k < MASK_COUNT_MAX; k++) begin
         masks[k] = pair_ff[k / 2][(k % 2) * TAPS +: TAPS];
      end
   end

   assign threshold = thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p < PAIR_COUNT; p++) begin
            pair_ff[p] <= '0;
         end
         thr_ff <= THRESHOLD_RESET;
      end else begin
         pair_ff <= pair_in;
         thr_ff  <= thr_in;
      end
   end

endmodule

// ===== sv/cpa_window.sv =====
// 5x5 window shift register and column counter; first pipeline stage.
// Depends on cpa_pkg.
module cpa_window (
   input  logic                clock,
   input  logic                reset,
   input  logic                col_valid,
   output logic                col_ready,
   input  cpa_pkg::column_type col_pix,
   input  logic                row_start,
   output logic                win_valid,
   output cpa_pkg::window_type win_pix,
   input  logic                win_ready
);
   import cpa_pkg::*;

   window_type        win_ff;
   window_type        win_in;
   logic [COLS_W-1:0] cols_ff;
   logic [COLS_W-1:0] cols_in;
   logic              valid_ff;
   logic              valid_in;
   logic              accept;

   assign col_ready = !valid_ff || win_ready;
   assign accept    = col_valid && col_ready;

   always_comb begin
      win_in   = win_ff;
      cols_in  = cols_ff;
      valid_in = valid_ff;
      if (col_ready) begin
         valid_in = 1'b0;
      end
      if (accept) begin
         // shift each row left, new column enters on the right
         for (int r = 0; r < WIN; r++) begin
            for (int c = 0; c < WIN - 1; c++) begin
               win_in[r * WIN + c] = win_ff[r * WIN + c + 1];
            end
            win_in[r * WIN + WIN - 1] = col_pix[r];
         end
         if (row_start) begin
            cols_in = COLS_W'(1);
         end else if (cols_ff < COLS_W'(WIN)) begin
            cols_in = cols_ff + COLS_W'(1);
         end
         valid_in = (cols_in == COLS_W'(WIN));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff   <= '0;
         cols_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         win_ff   <= win_in;
         cols_ff  <= cols_in;
         valid_ff <= valid_in;
      end
   end

   assign win_valid = valid_ff;
   assign win_pix   = win_ff;

endmodule

// ===== sv/cpa_mask_sum.sv =====
// Masked row sums (stage 2) and per-mask totals divided by nine (stage 3).
// Depends on cpa_pkg.
module cpa_mask_sum #(
   parameter int MASK_COUNT = cpa_pkg::MASK_COUNT_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  win_valid,
   output logic                  win_ready,
   input  cpa_pkg::window_type   win_pix,
   input  cpa_pkg::mask_set_type masks,
   output cpa_pkg::stage_tag_type mean_tag,
   output cpa_pkg::mean_type     means [MASK_COUNT],
   input  logic                  mean_ready
);
   import cpa_pkg::*;

   logic [ROW_SUM_W-1:0] row_sum_in [MASK_COUNT][WIN];
   logic [ROW_SUM_W-1:0] row_sum_ff [MASK_COUNT][WIN];
   stage_tag_type        sum_tag_ff;
   logic [TOTAL_W-1:0]   total [MASK_COUNT];
   logic [PROD_W-1:0]    prod  [MASK_COUNT];
   mean_type             mean_in [MASK_COUNT];
   mean_type             mean_ff [MASK_COUNT];
   stage_tag_type        mean_tag_ff;
   logic                 sum_ready;
   logic                 mean_load;

   assign mean_load = !mean_tag_ff.valid || mean_ready;
   assign sum_ready = !sum_tag_ff.valid || mean_load;
   assign win_ready = sum_ready;

   always_comb begin
      for (int k = 0; k < MASK_COUNT; k++) begin
         for (int r = 0; r < WIN; r++) begin
            row_sum_in[k][r] = '0;
            for (int c = 0; c < WIN; c++) begin
               if (masks[k][r * WIN + c]) begin
                  row_sum_in[k][r] = row_sum_in[k][r] + ROW_SUM_W'(win_pix[r * WIN + c]);
               end
            end
         end
      end
   end

   // Divide by nine through the reciprocal multiply
   always_comb begin
      for (int k = 0; k < MASK_COUNT; k++) begin
         total[k] = '0;
         for (int r = 0; r < WIN; r++) begin
            total[k] = total[k] + TOTAL_W'(row_sum_ff[k][r]);
         end
         prod[k]    = PROD_W'(total[k]) * PROD_W'(RECIP_9);
         mean_in[k] = prod[k][RECIP_SHIFT +: MEAN_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_tag_ff.valid  <= 1'b0;
         mean_tag_ff.valid <= 1'b0;
      end else begin
         if (sum_ready) begin
            sum_tag_ff.valid <= win_valid;
         end
         if (mean_load) begin
            mean_tag_ff.valid <= sum_tag_ff.valid;
         end
      end
      if (sum_ready && win_valid) begin
         row_sum_ff        <= row_sum_in;
         sum_tag_ff.centre <= win_pix[CENTRE_TAP];
      end
      if (mean_load && sum_tag_ff.valid) begin
         mean_ff            <= mean_in;
         mean_tag_ff.centre <= sum_tag_ff.centre;
      end
   end

   assign mean_tag = mean_tag_ff;
   assign means    = mean_ff;

endmodule

// ===== sv/cpa_select.sv =====
// Picks the mean closest to the centre pixel, saturates and thresholds it;
// holds the output register. Depends on cpa_pkg.
module cpa_select #(
   parameter int MASK_COUNT = cpa_pkg::MASK_COUNT_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cpa_pkg::stage_tag_type mean_tag,
   input  cpa_pkg::mean_type      means [MASK_COUNT],
   output logic                   mean_ready,
   input  cpa_pkg::pix_type       threshold,
   output logic                   out_valid,
   output cpa_pkg::pix_type       out_value,
   output logic                   out_above,
   input  logic                   out_ready
);
   import cpa_pkg::*;

   mean_type          best;
   logic [DIFF_W-1:0] best_diff;
   mean_type          diff;
   mean_type          centre;
   pix_type           value_in;
   logic              above_in;
   logic              valid_ff;
   pix_type           value_ff;
   logic              above_ff;

   assign mean_ready = !valid_ff || out_ready;
   assign centre     = MEAN_W'(mean_tag.centre);

   // Strict compare keeps the lowest mask index on ties
   always_comb begin
      best      = centre;
      best_diff = DIFF_START;
      diff      = '0;
      for (int k = 0; k < MASK_COUNT; k++) begin
         diff = (means[k] >= centre) ? (means[k] - centre) : (centre - means[k]);
         if (DIFF_W'(diff) < best_diff) begin
            best_diff = DIFF_W'(diff);
            best      = means[k];
         end
      end
      value_in = (best > MEAN_W'(PIX_MAX)) ? PIX_MAX : best[PIX_W-1:0];
      above_in = (best >= MEAN_W'(threshold));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (mean_ready) begin
         valid_ff <= mean_tag.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (mean_ready && mean_tag.valid) begin
         value_ff <= value_in;
         above_ff <= above_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_value = value_ff;
   assign out_above = above_ff;

endmodule

// ===== sv/corner_preserving_average_5x5_top.sv =====
// Corner-preserving 5x5 average: top level.
// Instantiates cpa_csr, cpa_window, cpa_mask_sum and cpa_select; depends on cpa_pkg.
//
// Usage:
//  - req channel carries one five-pixel column of a mirror-framed image per
//    transaction; req_tuser marks the first column of a row. Results start
//    once a row has supplied five columns, then one result per column.
//  - rsp channel carries the smoothed pixel (rsp_tdata) and its threshold bit
//    (rsp_tuser). Columns early in a row produce no transaction.
//  - csr port holds four 50-bit mask pairs (byte addresses 0, 8, 16, 24) and
//    the threshold (address 32). Write only while the pipeline is empty.
//  - Path: an accepted column passes the window, row-sum, divide and
//    select/output registers in that order before rsp_tvalid rises.
//  - Throughput: one column per clock unless the output stalls; the
//    divide-by-nine multiply and the select chain each sit in their own stage.
//  - Reset clears the window, the column count, all stage valids and the
//    registers to their defaults (masks zero, threshold 128).
//  - When rsp_tready is low, stages behind the output register keep filling
//    their bubbles; req_tready drops only once all four stages hold data.
module corner_preserving_average_5x5_top #(
   parameter int MASK_COUNT = cpa_pkg::MASK_COUNT_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   // req_tdata: pix_top2, pix_top1, pix_mid, pix_bot1, pix_bot2 (low to high)
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [cpa_pkg::WIN*cpa_pkg::PIX_W-1:0] req_tdata,
   // req_tuser: row_start
   input  logic                           req_tuser,
   // rsp_tdata: smoothed_value
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [cpa_pkg::PIX_W-1:0]      rsp_tdata,
   // rsp_tuser: above_threshold
   output logic                           rsp_tuser,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [cpa_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [cpa_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [cpa_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);
   import cpa_pkg::*;

   mask_set_type  masks;
   pix_type       threshold;
   column_type    col_pix;
   logic          win_valid;
   logic          win_ready;
   window_type    win_pix;
   stage_tag_type mean_tag;
   mean_type      means [MASK_COUNT];
   logic          mean_ready;

   assign col_pix = req_tdata;

   cpa_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .masks       (masks),
      .threshold   (threshold)
   );

   cpa_window u_window (
      .clock     (clock),
      .reset     (reset),
      .col_valid (req_tvalid),
      .col_ready (req_tready),
      .col_pix   (col_pix),
      .row_start (req_tuser),
      .win_valid (win_valid),
      .win_pix   (win_pix),
      .win_ready (win_ready)
   );

   cpa_mask_sum #(
      .MASK_COUNT (MASK_COUNT)
   ) u_mask_sum (
      .clock      (clock),
      .reset      (reset),
      .win_valid  (win_valid),
      .win_ready  (win_ready),
      .win_pix    (win_pix),
      .masks      (masks),
      .mean_tag   (mean_tag),
      .means      (means),
      .mean_ready (mean_ready)
   );

   cpa_select #(
      .MASK_COUNT (MASK_COUNT)
   ) u_select (
      .clock      (clock),
      .reset      (reset),
      .mean_tag   (mean_tag),
      .means      (means),
      .mean_ready (mean_ready),
      .threshold  (threshold),
      .out_valid  (rsp_tvalid),
      .out_value  (rsp_tdata),
      .out_above  (rsp_tuser),
      .out_ready  (rsp_tready)
   );

endmodule

// ===== sv/cpa_checker.sv =====
// Port-level checker for corner_preserving_average_5x5_top, bound to the top.
// Depends on cpa_pkg and corner_preserving_average_5x5_top_macros.svh.
`include "corner_preserving_average_5x5_top_macros.svh"

module cpa_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_tready,
   input logic                      rsp_tvalid,
   input logic                      rsp_tready,
   input logic [cpa_pkg::PIX_W-1:0] rsp_tdata,
   input logic                      rsp_tuser,
   input logic                      csr_pready
);

   // A stalled result holds its data
   `CPA_ASSERT_NXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled rsp transaction changed")

   // Input backpressure only when every stage is full and the output is stalled
   `CPA_ASSERT_IMP(a_req_backpressure, !req_tready, rsp_tvalid && !rsp_tready, "req_tready low without output stall")

   // Reset empties the pipeline
   `CPA_ASSERT_RST(a_reset_empty, !rsp_tvalid && req_tready, "pipeline not empty after reset")

   // Configuration port never waits
   `CPA_ASSERT_IMP(a_csr_ready, 1'b1, csr_pready, "csr_pready deasserted")

endmodule

bind corner_preserving_average_5x5_top cpa_checker u_checker (.*);
